[src/esc_pwm_pkg.sv]
// Shared constants and scaling functions for the ESC pulse-width mapper.
package esc_pwm_pkg;

    localparam int CMP_W = 14;
    localparam int PM_W = 16;
    localparam int CLAMP_W = 10;
    localparam int RB_W = 12;
    localparam int MODE_W = 3;
    localparam int DIR_W = 2;

    localparam logic [CMP_W-1:0] NEUTRAL_CMP = 14'd9211;
    localparam logic [CMP_W-1:0] BRAKE_CMP = 14'd6141;
    localparam logic [PM_W-1:0] PM_MAX = 16'd1000;

    // span * v / 1000 folded into one constant: (v * span/10 * ceil(2^25/100)) >> 25
    localparam int SCALE_SHIFT = 25;
    localparam int SCALE_PROD_W = 38;
    localparam logic [SCALE_PROD_W-1:0] FWD_MUL = 38'd103012315;
    localparam logic [SCALE_PROD_W-1:0] BACK_MUL = 38'd103347860;

    // d * 1000 / span folded: (d * 100 * ceil(2^30/(span/10))) >> 30
    localparam int RB_SHIFT = 30;
    localparam int RB_PROD_W = 44;
    localparam logic [RB_PROD_W-1:0] RB_FWD_MUL = 44'd349753100;
    localparam logic [RB_PROD_W-1:0] RB_BACK_MUL = 44'd348617500;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FWD_FREE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FWD_BRAKE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BACK_FREE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BACK_BRAKE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BRAKE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FREERUN = 3'd5;

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_MODE = 1'b1;

    function automatic logic [CMP_W-1:0] fwd_cmp(input logic [CLAMP_W-1:0] v);
        logic [SCALE_PROD_W-1:0] prod;
        begin
            prod = SCALE_PROD_W'(v) * FWD_MUL;
            return CMP_W'(prod >> SCALE_SHIFT) + NEUTRAL_CMP;
        end
    endfunction

    function automatic logic [CMP_W-1:0] back_cmp(input logic [CLAMP_W-1:0] v);
        logic [SCALE_PROD_W-1:0] prod;
        begin
            prod = SCALE_PROD_W'(v) * BACK_MUL;
            return NEUTRAL_CMP - CMP_W'(prod >> SCALE_SHIFT);
        end
    endfunction

endpackage

[src/esc_pulse_width_mapper.sv]
// Top level of the two-channel ESC pulse-width mapper.
//
//  channel | dir | fields (low bit up)
//  s_*     | in  | tuser: opcode, side; tdata: pulse_pm, mode_request
//  m_*     | out | tdata: left_compare, right_compare, pulse_readback, mode_report
//
// Three register stages: input word, state update, read-back; one word per cycle while the output is not stalled.
// The read-back multiplier sits alone in the last stage.
// Reset puts both compares at neutral (9211) and the direction at forward.
// A stalled output holds the pipe; stages with no word still fill.
module esc_pulse_width_mapper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pulse_pm[15:0], mode_request[18:16], zero pad
    input  logic [1:0]  s_tuser,   // opcode[0], side[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // left_compare[13:0], right_compare[27:14],
                                   // pulse_readback[39:28], mode_report[42:40], zero pad
);

    localparam int CW = esc_pwm_pkg::CMP_W;
    localparam int MW = esc_pwm_pkg::MODE_W;
    localparam int DW = esc_pwm_pkg::DIR_W;

    // input stage
    logic                               v1_reg;
    logic                               op_reg;
    logic                               side_reg;
    logic [esc_pwm_pkg::PM_W-1:0]       pm_reg;
    logic [MW-1:0]                      mode_req_reg;

    // state
    logic [CW-1:0]                      left_cmp_reg, left_cmp_next;
    logic [CW-1:0]                      right_cmp_reg, right_cmp_next;
    logic [DW-1:0]                      dir_reg, dir_next;

    // middle stage
    logic                               v2_reg;
    logic [CW-1:0]                      mid_left_reg;
    logic [CW-1:0]                      mid_right_reg;
    logic [CW-1:0]                      mid_sel_reg;
    logic [MW-1:0]                      mid_mode_reg;

    // output stage
    logic                               v3_reg;
    logic [CW-1:0]                      out_left_reg;
    logic [CW-1:0]                      out_right_reg;
    logic [esc_pwm_pkg::RB_W-1:0]       out_rb_reg;
    logic [MW-1:0]                      out_mode_reg;

    logic                               adv1, adv2, adv3;
    logic [esc_pwm_pkg::CLAMP_W-1:0]    clamped;
    logic [CW-1:0]                      new_cmp;
    logic [MW-1:0]                      mode_next;
    logic [esc_pwm_pkg::RB_W-1:0]       readback;

    assign adv3 = !v3_reg || m_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_tready = adv1;

    always_comb
    begin
        clamped = (pm_reg > esc_pwm_pkg::PM_MAX) ? esc_pwm_pkg::CLAMP_W'(esc_pwm_pkg::PM_MAX)
                                                 : esc_pwm_pkg::CLAMP_W'(pm_reg);
        case (dir_reg)
            esc_pwm_pkg::DIR_FWD:  new_cmp = esc_pwm_pkg::fwd_cmp(clamped);
            esc_pwm_pkg::DIR_BACK: new_cmp = esc_pwm_pkg::back_cmp(clamped);
            default:               new_cmp = CW'(clamped);
        endcase

        left_cmp_next = left_cmp_reg;
        right_cmp_next = right_cmp_reg;
        dir_next = dir_reg;
        if (op_reg == esc_pwm_pkg::OP_PULSE)
        begin
            if (side_reg)
                right_cmp_next = new_cmp;
            else
                left_cmp_next = new_cmp;
        end
        else
        begin
            case (mode_req_reg)
                esc_pwm_pkg::MODE_FWD_FREE, esc_pwm_pkg::MODE_FWD_BRAKE:
                    dir_next = esc_pwm_pkg::DIR_FWD;
                esc_pwm_pkg::MODE_BACK_FREE, esc_pwm_pkg::MODE_BACK_BRAKE:
                    dir_next = esc_pwm_pkg::DIR_BACK;
                esc_pwm_pkg::MODE_BRAKE:
                begin
                    left_cmp_next = esc_pwm_pkg::BRAKE_CMP;
                    right_cmp_next = esc_pwm_pkg::BRAKE_CMP;
                    dir_next = esc_pwm_pkg::DIR_STOP;
                end
                esc_pwm_pkg::MODE_FREERUN:
                begin
                    left_cmp_next = esc_pwm_pkg::NEUTRAL_CMP;
                    right_cmp_next = esc_pwm_pkg::NEUTRAL_CMP;
                    dir_next = esc_pwm_pkg::DIR_STOP;
                end
                default:
                begin
                end
            endcase
        end

        if (dir_next == esc_pwm_pkg::DIR_FWD)
            mode_next = esc_pwm_pkg::MODE_FWD_FREE;
        else if (dir_next == esc_pwm_pkg::DIR_BACK)
            mode_next = esc_pwm_pkg::MODE_BACK_FREE;
        else if (left_cmp_next == esc_pwm_pkg::NEUTRAL_CMP
                 && right_cmp_next == esc_pwm_pkg::NEUTRAL_CMP)
            mode_next = esc_pwm_pkg::MODE_FREERUN;
        else
            mode_next = esc_pwm_pkg::MODE_BRAKE;
    end

    esc_pwm_readback u_readback
    (
        .cmp      (mid_sel_reg),
        .readback (readback)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            left_cmp_reg <= esc_pwm_pkg::NEUTRAL_CMP;
            right_cmp_reg <= esc_pwm_pkg::NEUTRAL_CMP;
            dir_reg <= esc_pwm_pkg::DIR_FWD;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (v1_reg && adv2)
            begin
                left_cmp_reg <= left_cmp_next;
                right_cmp_reg <= right_cmp_next;
                dir_reg <= dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid)
        begin
            op_reg <= s_tuser[0];
            side_reg <= s_tuser[1];
            pm_reg <= s_tdata[15:0];
            mode_req_reg <= s_tdata[18:16];
        end
        if (adv2 && v1_reg)
        begin
            mid_left_reg <= left_cmp_next;
            mid_right_reg <= right_cmp_next;
            mid_sel_reg <= side_reg ? right_cmp_next : left_cmp_next;
            mid_mode_reg <= mode_next;
        end
        if (adv3 && v2_reg)
        begin
            out_left_reg <= mid_left_reg;
            out_right_reg <= mid_right_reg;
            out_rb_reg <= readback;
            out_mode_reg <= mid_mode_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata = {5'd0, out_mode_reg, out_rb_reg, out_right_reg, out_left_reg};

endmodule

[src/esc_pwm_readback.sv]
// Per-mille read-back recovered from a compare value.
module esc_pwm_readback
(
    input  logic [esc_pwm_pkg::CMP_W-1:0] cmp,
    output logic [esc_pwm_pkg::RB_W-1:0]  readback
);

    logic                                  above;
    logic [esc_pwm_pkg::CMP_W-1:0]         delta;
    logic [esc_pwm_pkg::RB_PROD_W-1:0]     mul;
    logic [esc_pwm_pkg::RB_PROD_W-1:0]     prod;

    always_comb
    begin
        above = cmp > esc_pwm_pkg::NEUTRAL_CMP;
        delta = above ? cmp - esc_pwm_pkg::NEUTRAL_CMP : esc_pwm_pkg::NEUTRAL_CMP - cmp;
        mul = above ? esc_pwm_pkg::RB_FWD_MUL : esc_pwm_pkg::RB_BACK_MUL;
        prod = esc_pwm_pkg::RB_PROD_W'(delta) * mul;
        readback = esc_pwm_pkg::RB_W'(prod >> esc_pwm_pkg::RB_SHIFT);
    end

endmodule

[tb/sv/tb_esc_pulse_width_mapper.sv]
// Self-checking testbench for the ESC pulse-width mapper: directed and random commands, checked word by word.
`timescale 1ns / 100ps

module tb_esc_pulse_width_mapper;

    localparam int unsigned FWD_SPAN = 3070;
    localparam int unsigned BACK_SPAN = 3080;
    localparam logic [esc_pwm_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [esc_pwm_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;
    localparam int RANDOM_PER_PHASE = 388;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [esc_pwm_pkg::CMP_W-1:0]  left_cmp;
        logic [esc_pwm_pkg::CMP_W-1:0]  right_cmp;
        logic [esc_pwm_pkg::RB_W-1:0]   readback;
        logic [esc_pwm_pkg::MODE_W-1:0] mode;
    } esc_word_t;

    class compare_tracker;
        logic [esc_pwm_pkg::CMP_W-1:0] left_cmp;
        logic [esc_pwm_pkg::CMP_W-1:0] right_cmp;
        logic [esc_pwm_pkg::DIR_W-1:0] dir;
        esc_word_t        pending[$];
        int               errors;
        int               checked;
        int               mode_cmds;
        int               stopped_pulses;

        function new();
            left_cmp = esc_pwm_pkg::NEUTRAL_CMP;
            right_cmp = esc_pwm_pkg::NEUTRAL_CMP;
            dir = esc_pwm_pkg::DIR_FWD;
            errors = 0;
            checked = 0;
            mode_cmds = 0;
            stopped_pulses = 0;
        endfunction

        function logic [esc_pwm_pkg::RB_W-1:0] readback_of(
            logic [esc_pwm_pkg::CMP_W-1:0] c);
            int unsigned r;
            if (c > esc_pwm_pkg::NEUTRAL_CMP)
                r = (int'(c) - int'(esc_pwm_pkg::NEUTRAL_CMP)) * 1000 / FWD_SPAN;
            else if (c < esc_pwm_pkg::NEUTRAL_CMP)
                r = (int'(esc_pwm_pkg::NEUTRAL_CMP) - int'(c)) * 1000 / BACK_SPAN;
            else
                r = 0;
            return r[esc_pwm_pkg::RB_W-1:0];
        endfunction

        function logic [esc_pwm_pkg::MODE_W-1:0] mode_of();
            if (dir == esc_pwm_pkg::DIR_FWD)
                return esc_pwm_pkg::MODE_FWD_FREE;
            if (dir == esc_pwm_pkg::DIR_BACK)
                return esc_pwm_pkg::MODE_BACK_FREE;
            if (left_cmp == esc_pwm_pkg::BRAKE_CMP && right_cmp == esc_pwm_pkg::BRAKE_CMP)
                return esc_pwm_pkg::MODE_BRAKE;
            if (left_cmp == esc_pwm_pkg::NEUTRAL_CMP && right_cmp == esc_pwm_pkg::NEUTRAL_CMP)
                return esc_pwm_pkg::MODE_FREERUN;
            return esc_pwm_pkg::MODE_BRAKE;
        endfunction

        function void note_command(logic op, logic side, logic [esc_pwm_pkg::PM_W-1:0] pm,
                                   logic [esc_pwm_pkg::MODE_W-1:0] mode);
            int unsigned v;
            esc_word_t   w;
            if (op == esc_pwm_pkg::OP_PULSE)
            begin
                v = (pm > esc_pwm_pkg::PM_MAX) ? int'(esc_pwm_pkg::PM_MAX) : int'(pm);
                if (dir == esc_pwm_pkg::DIR_FWD)
                    v = FWD_SPAN * v / 1000 + int'(esc_pwm_pkg::NEUTRAL_CMP);
                else if (dir == esc_pwm_pkg::DIR_BACK)
                    v = int'(esc_pwm_pkg::NEUTRAL_CMP) - BACK_SPAN * v / 1000;
                else
                    stopped_pulses++;
                if (side == 1'b0)
                    left_cmp = v[esc_pwm_pkg::CMP_W-1:0];
                else
                    right_cmp = v[esc_pwm_pkg::CMP_W-1:0];
            end
            else
            begin
                mode_cmds++;
                case (mode)
                    esc_pwm_pkg::MODE_FWD_FREE, esc_pwm_pkg::MODE_FWD_BRAKE:
                        dir = esc_pwm_pkg::DIR_FWD;
                    esc_pwm_pkg::MODE_BACK_FREE, esc_pwm_pkg::MODE_BACK_BRAKE:
                        dir = esc_pwm_pkg::DIR_BACK;
                    esc_pwm_pkg::MODE_BRAKE:
                    begin
                        left_cmp = esc_pwm_pkg::BRAKE_CMP;
                        right_cmp = esc_pwm_pkg::BRAKE_CMP;
                        dir = esc_pwm_pkg::DIR_STOP;
                    end
                    esc_pwm_pkg::MODE_FREERUN:
                    begin
                        left_cmp = esc_pwm_pkg::NEUTRAL_CMP;
                        right_cmp = esc_pwm_pkg::NEUTRAL_CMP;
                        dir = esc_pwm_pkg::DIR_STOP;
                    end
                    default: ;
                endcase
            end
            w.left_cmp = left_cmp;
            w.right_cmp = right_cmp;
            w.readback = readback_of(side == 1'b0 ? left_cmp : right_cmp);
            w.mode = mode_of();
            pending.push_back(w);
        endfunction

        function void report(string field, int unsigned exp_v, logic [15:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
        endfunction

        function void check_word(logic [47:0] data);
            esc_word_t w;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, data);
                return;
            end
            w = pending.pop_front();
            checked++;
            if (data[13:0] !== w.left_cmp)
                report("left_compare", w.left_cmp, 16'(data[13:0]));
            if (data[27:14] !== w.right_cmp)
                report("right_compare", w.right_cmp, 16'(data[27:14]));
            if (data[39:28] !== w.readback)
                report("pulse_readback", w.readback, 16'(data[39:28]));
            if (data[42:40] !== w.mode)
                report("mode_report", w.mode, 16'(data[42:40]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int             src_idle_pct = 0;
    int             sink_stall_pct = 0;
    int             sent = 0;
    compare_tracker tracker = new();

    esc_pulse_width_mapper DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_cmd(logic op, logic side, logic [esc_pwm_pkg::PM_W-1:0] pm,
                            logic [esc_pwm_pkg::MODE_W-1:0] mode);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {side, op};
        s_tdata <= {5'b0, mode, pm};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_command(op, side, pm, mode);
        sent++;
    endtask

    function automatic logic [esc_pwm_pkg::PM_W-1:0] pick_pulse();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return esc_pwm_pkg::PM_W'($urandom_range(0, 1000));
        if (r < 80)
            return esc_pwm_pkg::PM_W'($urandom_range(999, 1001));
        if (r < 85)
            return 16'd0;
        return esc_pwm_pkg::PM_W'($urandom);
    endfunction

    task automatic run_random(int n);
        logic [esc_pwm_pkg::MODE_W-1:0] mode;
        repeat (n)
        begin
            mode = esc_pwm_pkg::MODE_W'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 25)
                send_cmd(esc_pwm_pkg::OP_MODE, 1'($urandom),
                         esc_pwm_pkg::PM_W'($urandom), mode);
            else
                send_cmd(esc_pwm_pkg::OP_PULSE, 1'($urandom), pick_pulse(), mode);
        end
    endtask

    // result side: check accepted words, then redraw tready
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_word(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, forward scaling and clamp
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b0, 16'd0, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b1, 16'd1000, MODE_SPARE_7);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b0, 16'hFFFF, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b1, 16'd1001, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b0, 16'h8000, esc_pwm_pkg::MODE_FWD_FREE);
        // backward: direction only, compares kept
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b0, 16'hFFFF, esc_pwm_pkg::MODE_BACK_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b0, 16'd1000, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b1, 16'd1, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b1, 16'h5555, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b1, 16'd0, esc_pwm_pkg::MODE_FWD_BRAKE);
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b0, 16'd0, esc_pwm_pkg::MODE_BACK_BRAKE);
        // stopped: brake, raw writes, mixed compares
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b0, 16'd0, esc_pwm_pkg::MODE_BRAKE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b0, 16'd500, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b1, 16'd0, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b1, 16'hAAAA, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b1, 16'd0, esc_pwm_pkg::MODE_FREERUN);
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b0, 16'h1234, MODE_SPARE_6);
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b1, 16'hFFFF, MODE_SPARE_7);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b0, 16'd1000, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b0, 16'd0, esc_pwm_pkg::MODE_FREERUN);
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b1, 16'd0, esc_pwm_pkg::MODE_BRAKE);
        send_cmd(esc_pwm_pkg::OP_MODE, 1'b1, 16'd0, esc_pwm_pkg::MODE_FWD_FREE);
        send_cmd(esc_pwm_pkg::OP_PULSE, 1'b1, 16'd999, esc_pwm_pkg::MODE_FWD_FREE);

        run_random(RANDOM_PER_PHASE);
        src_idle_pct = 63;
        run_random(RANDOM_PER_PHASE);
        src_idle_pct = 0;
        sink_stall_pct = 63;
        run_random(RANDOM_PER_PHASE);
        src_idle_pct = 34;
        sink_stall_pct = 34;
        run_random(RANDOM_PER_PHASE);
        s_tvalid <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands sent (%0d set-mode, %0d pulses while stopped), %0d words checked",
                 sent, tracker.mode_cmds, tracker.stopped_pulses, tracker.checked);
        $display("phases: free flow, source gaps, sink stalls, both; %0d mismatches",
                 tracker.errors);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
